>>> hw/rtl/skts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared sizes, status codes and the control types that run between the
// search controller and the row of key cells.
// ----------------------------------------------------------------------------
package skts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_POS_W = 8;
  localparam int OUT_CNT_W = 9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [OUT_CNT_W-1:0] FULL_COUNT = OUT_CNT_W'(TABLE_DEPTH);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    idx_t probe_idx;
    logic shift_en;
    idx_t slot;
  } cell_ctl_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cell_flags_t;

endpackage

>>> hw/rtl/skts_cell.sv
// ----------------------------------------------------------------------------
// Key cell
// Holds one table entry, answers a probe at its own index and takes the key
// of its lower neighbor when an insert opens a gap below it, or the new key when the insert lands on it.
// ----------------------------------------------------------------------------
module skts_cell
  import skts_pkg::*;
(
  input  logic        clk,
  input  idx_t        cell_idx,
  input  key_t        bcast_key,
  input  key_t        prev_key,
  input  cell_ctl_t   ctl,
  output key_t        key_q,
  output cell_flags_t flags
);

  key_t key_r;
  key_t key_nxt;
  logic sel;

  assign sel      = (ctl.probe_idx == cell_idx);
  assign flags.eq = sel && (key_r == bcast_key);
  assign flags.gt = sel && (key_r > bcast_key);
  assign key_q    = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.shift_en) begin
      if (cell_idx == ctl.slot) begin
        key_nxt = bcast_key;
      end else if (cell_idx > ctl.slot) begin
        key_nxt = prev_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

>>> hw/rtl/sorted_key_table_search_insert.sv
// ----------------------------------------------------------------------------
// Sorted key table with binary search and ordered insert
// Keeps keys in ascending order in a row of cells and serves one command at
// a time.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// in_command selects a lookup or an insert of in_search_key. Each transaction
// gives exactly one result, shown on the out_ ports for one cycle with
// out_valid high. The receiver cannot stall, so the result must be taken then.
// A lookup probes one middle index per cycle until it hits or its range is
// empty. An insert runs a lower-bound search at one probe per cycle, then
// shifts the cells above the slot and writes the key; a table that still
// takes an insert holds at most 255 keys. An insert into a full table
// answers from idle without raising busy. The result appears in the
// same cycle in which busy falls, and a new transaction may be accepted in
// that cycle. The probe rate is set by one compare per cycle on the shared
// probe bus of the cell row. Reset empties the table at once (count cleared);
// cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert
  import skts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [KEY_BITS-1:0]  in_search_key,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [OUT_POS_W-1:0] out_position,
  output logic [OUT_CNT_W-1:0] out_entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_BOUND
  } state_t;

  state_t      state_r;
  cnt_t        count_r;
  cnt_t        left_r;
  cnt_t        right_r;
  key_t        key_r;
  logic        out_valid_r;
  logic [1:0]  status_r;
  idx_t        pos_r;

  cell_ctl_t   ctl;
  cell_flags_t flags [TABLE_DEPTH];
  key_t        cell_keys [TABLE_DEPTH];
  cell_flags_t hit;

  logic [CNT_W:0] find_sum;
  logic [CNT_W:0] bound_sum;
  idx_t           find_mid;
  idx_t           bound_mid;
  cnt_t           probe_p1;
  logic           open_range;

  assign find_sum   = {1'b0, left_r} + {1'b0, right_r} - (CNT_W + 1)'(1);
  assign bound_sum  = {1'b0, left_r} + {1'b0, right_r};
  assign find_mid   = IDX_W'(find_sum >> 1);
  assign bound_mid  = IDX_W'(bound_sum >> 1);
  assign open_range = (left_r < right_r);

  always_comb begin
    ctl.probe_idx = (state_r == S_FIND) ? find_mid : bound_mid;
    ctl.shift_en  = (state_r == S_BOUND) && !open_range;
    ctl.slot      = IDX_W'(left_r);
  end

  assign probe_p1 = CNT_W'(ctl.probe_idx) + CNT_W'(1);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      skts_cell u_cell (
        .clk       (clk),
        .cell_idx  (IDX_W'(gi)),
        .bcast_key (key_r),
        .prev_key  ((gi == 0) ? key_r : cell_keys[(gi == 0) ? 0 : gi - 1]),
        .ctl       (ctl),
        .key_q     (cell_keys[gi]),
        .flags     (flags[gi])
      );
    end
  endgenerate

  always_comb begin
    hit = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit.eq = hit.eq | flags[i].eq;
      hit.gt = hit.gt | flags[i].gt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            key_r   <= in_search_key;
            left_r  <= '0;
            right_r <= count_r;
            if (in_command == CMD_LOOKUP) begin
              state_r <= S_FIND;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              out_valid_r <= 1'b1;
              status_r    <= ST_FULL;
              pos_r       <= '0;
            end else begin
              state_r <= S_BOUND;
            end
          end
        end
        S_FIND: begin
          if (!open_range) begin
            out_valid_r <= 1'b1;
            status_r    <= ST_MISS;
            pos_r       <= '0;
            state_r     <= S_IDLE;
          end else if (hit.eq) begin
            out_valid_r <= 1'b1;
            status_r    <= ST_OK;
            pos_r       <= ctl.probe_idx;
            state_r     <= S_IDLE;
          end else if (hit.gt) begin
            right_r <= CNT_W'(ctl.probe_idx);
          end else begin
            left_r <= probe_p1;
          end
        end
        S_BOUND: begin
          if (!open_range) begin
            count_r     <= count_r + CNT_W'(1);
            out_valid_r <= 1'b1;
            status_r    <= ST_OK;
            pos_r       <= IDX_W'(left_r);
            state_r     <= S_IDLE;
          end else if (!hit.eq && !hit.gt) begin
            left_r <= probe_p1;
          end else begin
            right_r <= CNT_W'(ctl.probe_idx);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = OUT_POS_W'(pos_r);
  assign out_entry_count = OUT_CNT_W'(count_r);

endmodule

>>> hw/rtl/skts_checker.sv
// ----------------------------------------------------------------------------
// Sorted key table port checker
// Watches the top-level ports for command and result consistency over time.
// ----------------------------------------------------------------------------
module skts_checker
  import skts_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [1:0]           out_status,
  input logic [OUT_POS_W-1:0] out_position,
  input logic [OUT_CNT_W-1:0] out_entry_count
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("Block not idle after reset.");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("Accepted transaction neither in progress nor answered.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_MISS ||
                  out_status == ST_FULL)
    else $error("Result carries an undefined status.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == FULL_COUNT &&
                                           out_position == '0)
    else $error("Full-table result with wrong count or position.");

  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS |-> out_position == '0)
    else $error("Missed lookup reports a nonzero position.");

endmodule

bind sorted_key_table_search_insert skts_checker u_skts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count)
);
